// ----- src/sha256_pkg.sv -----
`timescale 1ns / 1ps

package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenBits    = 61;

  localparam logic [7:0] PadByte = 8'h80;

  // controller to datapath commands
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD_BYTE,
    CMD_PAD_START,
    CMD_ZERO_BLOCK,
    CMD_LOAD_LEN
  } buf_cmd_t;

  typedef struct packed {
    buf_cmd_t   buf_cmd;
    logic       round_start;
    logic       round_step;
    logic       chain_add;
    logic       chain_init;
    logic       len_clear;
    logic [7:0] byte_in;
    logic [5:0] round_idx;
    logic [2:0] out_idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       fill_full;
  } dp_stat_t;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- src/sha256_datapath.sv -----
`timescale 1ns / 1ps

module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::dp_ctrl_t ctrl,
  output sha256_pkg::dp_stat_t stat,
  output logic [31:0]          digest_word
);

  // byte buffer as sixteen big-endian words; message bytes are written one at a time
  logic [31:0] w_r [16];
  logic [5:0]  fill_r;
  logic [60:0] len_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];

  logic [31:0] s0, s1, w_new, w_cur, t1, t2;
  logic [63:0] bits;

  assign bits  = {len_r, 3'b000};
  assign w_cur = w_r[0];
  assign s0 = sha256_pkg::ror32(w_r[1], 7) ^ sha256_pkg::ror32(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1 = sha256_pkg::ror32(w_r[14], 17) ^ sha256_pkg::ror32(w_r[14], 19)
            ^ (w_r[14] >> 10);
  assign w_new = w_r[0] + s0 + w_r[9] + s1;

  assign t1 = v_r[7]
            + (sha256_pkg::ror32(v_r[4], 6) ^ sha256_pkg::ror32(v_r[4], 11)
               ^ sha256_pkg::ror32(v_r[4], 25))
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha256_pkg::RoundK[ctrl.round_idx] + w_cur;
  assign t2 = (sha256_pkg::ror32(v_r[0], 2) ^ sha256_pkg::ror32(v_r[0], 13)
               ^ sha256_pkg::ror32(v_r[0], 22))
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign stat.fill      = fill_r;
  assign stat.fill_full = (fill_r == 6'd63);
  assign digest_word    = h_r[ctrl.out_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitH[i];
    end else begin
      unique case (ctrl.buf_cmd)
        sha256_pkg::CMD_LOAD_BYTE: begin
          w_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= ctrl.byte_in;
          fill_r <= fill_r + 6'd1;
          len_r  <= len_r + 61'd1;
        end
        sha256_pkg::CMD_PAD_START: begin
          // pad byte then zeros to block end
          for (int b = 0; b < 64; b++) begin
            if (b[5:0] == fill_r)
              w_r[b/4][8*(3-(b%4)) +: 8] <= sha256_pkg::PadByte;
            else if (b[5:0] > fill_r)
              w_r[b/4][8*(3-(b%4)) +: 8] <= 8'h00;
          end
        end
        sha256_pkg::CMD_ZERO_BLOCK: begin
          for (int i = 0; i < 16; i++) w_r[i] <= '0;
        end
        sha256_pkg::CMD_LOAD_LEN: begin
          w_r[14] <= bits[63:32];
          w_r[15] <= bits[31:0];
        end
        sha256_pkg::CMD_NONE: ;
        default: ;
      endcase
      if (ctrl.round_start) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      if (ctrl.round_step) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
      end
      if (ctrl.chain_add) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (ctrl.chain_init) begin
        for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::InitH[i];
      end
      if (ctrl.len_clear) begin
        len_r  <= '0;
        fill_r <= '0;
      end
    end
  end

endmodule

// ----- src/sha256_ctrl.sv -----
`timescale 1ns / 1ps

module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_msg_byte,
  input  logic                 in_has_byte,
  input  logic                 in_end_of_message,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_word_index,
  output logic                 out_last_word,
  output logic                 final_start,
  input  sha256_pkg::dp_stat_t stat,
  output sha256_pkg::dp_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND_START, S_ROUNDS, S_ADD, S_PAD, S_OUT
  } state_t;

  // what follows a compression
  typedef enum logic [1:0] {
    NX_IDLE, NX_PAD, NX_LEN, NX_OUT
  } next_t;

  state_t     state_r;
  next_t      after_r;
  logic       pend_end_r;
  logic [5:0] rnd_r;
  logic [2:0] idx_r;
  logic       acc;

  assign in_ready       = (state_r == S_IDLE);
  assign acc            = in_valid && in_ready;
  assign out_valid      = (state_r == S_OUT);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == 3'd7);
  assign final_start    = (state_r == S_ROUND_START) && pend_end_r;

  always_comb begin
    ctrl = '0;
    ctrl.byte_in   = in_msg_byte;
    ctrl.round_idx = rnd_r;
    ctrl.out_idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_has_byte) ctrl.buf_cmd = sha256_pkg::CMD_LOAD_BYTE;
      end
      S_ROUND_START: ctrl.round_start = 1'b1;
      S_ROUNDS:      ctrl.round_step  = 1'b1;
      S_ADD: begin
        ctrl.chain_add = 1'b1;
        if (after_r == NX_LEN) ctrl.buf_cmd = sha256_pkg::CMD_ZERO_BLOCK;
      end
      S_PAD:         ctrl.buf_cmd = sha256_pkg::CMD_PAD_START;
      S_OUT: begin
        if (out_ready && idx_r == 3'd7) begin
          ctrl.chain_init = 1'b1;
          ctrl.len_clear  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      after_r    <= NX_IDLE;
      pend_end_r <= 1'b0;
      rnd_r      <= '0;
      idx_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (in_has_byte && stat.fill_full) begin
              state_r <= S_ROUND_START;
              after_r <= in_end_of_message ? NX_PAD : NX_IDLE;
            end else if (in_end_of_message) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // room for the length in this block or not
          state_r <= S_ROUND_START;
          after_r <= (stat.fill >= 6'd56) ? NX_LEN : NX_OUT;
          pend_end_r <= (stat.fill < 6'd56);
        end
        S_ROUND_START: begin
          state_r <= S_ROUNDS;
          rnd_r   <= '0;
          if (pend_end_r) begin
            pend_end_r <= 1'b0;
          end
        end
        S_ROUNDS: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          unique case (after_r)
            NX_IDLE: state_r <= S_IDLE;
            NX_PAD:  state_r <= S_PAD;
            NX_LEN: begin
              // length-only block comes next and ends in the digest
              state_r    <= S_ROUND_START;
              after_r    <= NX_OUT;
              pend_end_r <= 1'b1;
            end
            NX_OUT: begin
              state_r <= S_OUT;
              idx_r   <= '0;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/sha256_lenload.sv -----
`timescale 1ns / 1ps

// merges length load into the buffer command ahead of the final compression
module sha256_lenload (
  input  sha256_pkg::dp_ctrl_t ctrl_in,
  input  logic                 final_start,
  output sha256_pkg::dp_ctrl_t ctrl_out
);

  always_comb begin
    ctrl_out = ctrl_in;
    if (final_start) ctrl_out.buf_cmd = sha256_pkg::CMD_LOAD_LEN;
  end

endmodule

// ----- src/sha256_hasher.sv -----
`timescale 1ns / 1ps
// byte items: one per cycle while in_ready is high; a byte that fills the block runs a
// compression (64 rounds, one shared round unit, plus start and chain add) before the
// next item is taken; end of message: padding and the last one or two compressions, then
// eight digest items one per cycle while out_ready is high; then items are taken again
// reset (rst_n low, synchronous) loads the initial chain and clears length and fill

module sha256_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word,
  output logic        out_valid,
  input  logic        out_ready
);

  sha256_pkg::dp_ctrl_t ctrl_raw, ctrl;
  sha256_pkg::dp_stat_t stat;
  logic                 final_start;

  // the length words go in on the start of the block that ends in the digest
  sha256_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_msg_byte       (in_msg_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .final_start       (final_start),
    .stat              (stat),
    .ctrl              (ctrl_raw)
  );

  sha256_lenload u_len (
    .ctrl_in     (ctrl_raw),
    .final_start (final_start),
    .ctrl_out    (ctrl)
  );

  sha256_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .stat        (stat),
    .digest_word (out_digest_word)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_msg_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;
  logic        out_valid;
  logic        out_ready = 1'b0;

  sha256_hasher u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_msg_byte       (in_msg_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready)
  );

  always #10 clk = ~clk;

  // one expected digest word
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  // one directed stimulus row; has_ref marks a digest typed in from known vectors
  typedef struct {
    logic [7:0]  data;
    logic        has_byte;
    logic        eom;
    bit          has_ref;
    logic [31:0] ref_w0;
  } stim_row_t;

  digest_item_t digest_q[$];

  // predictor state
  logic [31:0] hash_chain [8];
  logic [7:0]  msg_block [64];
  int unsigned block_cnt;
  logic [60:0] byte_total;

  int  fail_cnt = 0;
  int  items_sent = 0;
  int  digests_seen = 0;
  bit  quiet_mode = 1'b0;   // turns off random idling on both sides

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_chain[i] = sha256_pkg::InitH[i];
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    block_cnt = 0;
    byte_total = '0;
  endtask

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
    e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + sha256_pkg::RoundK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
    hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
  endtask

  // feed one accepted item into the predictor, queue the digest on end of message
  task automatic hash_item(logic [7:0] data, logic has_byte, logic eom);
    logic [63:0] bit_len;
    digest_item_t di;
    if (has_byte) begin
      msg_block[block_cnt] = data;
      block_cnt++;
      byte_total++;
      if (block_cnt == 64) begin
        compress();
        block_cnt = 0;
      end
    end
    if (eom) begin
      msg_block[block_cnt] = sha256_pkg::PadByte;
      for (int i = block_cnt + 1; i < 64; i++) msg_block[i] = '0;
      if (block_cnt >= 56) begin
        compress();
        for (int i = 0; i < 64; i++) msg_block[i] = '0;
      end
      bit_len = {byte_total, 3'b000};
      for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        di.word = hash_chain[i];
        di.idx  = i[2:0];
        di.last = (i == 7);
        digest_q.insert(digest_q.size(), di);
      end
      hash_reset();
    end
  endtask

  // drive one item and hold it until accepted
  task automatic send_item(logic [7:0] data, logic has_byte, logic eom);
    while (!quiet_mode && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_msg_byte       <= data;
    in_has_byte       <= has_byte;
    in_end_of_message <= eom;
    in_valid          <= 1'b1;
    do @(posedge clk); while (!in_ready);
    hash_item(data, has_byte, eom);
    items_sent++;
  endtask

  task automatic send_message(int len, bit with_end_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(255)), 1'b1, with_end_byte && (i == len - 1));
    if (!with_end_byte || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // receiver: random stall, check each accepted digest word against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_mode || ($urandom_range(99) >= 15);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("digest word with nothing expected: %h", out_digest_word);
          fail_cnt++;
        end else begin
          digest_item_t di;
          di = digest_q.pop_front();
          if (out_digest_word !== di.word) begin
            $error("digest_word expected %h actual %h", di.word, out_digest_word);
            fail_cnt++;
          end
          if (out_word_index !== di.idx) begin
            $error("word_index expected %0d actual %0d", di.idx, out_word_index);
            fail_cnt++;
          end
          if (out_last_word !== di.last) begin
            $error("last_word expected %0b actual %0b", di.last, out_last_word);
            fail_cnt++;
          end
          if (out_last_word) digests_seen++;
        end
      end
    end
  end

  // directed rows: known first digest words for the empty message and "abc"
  stim_row_t dir_rows [] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},  // empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},  // "abc", byte and end together
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},         // idle item, ignored
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h5a, 1'b0, 1'b1, 1'b0, 32'h0}          // end without byte
  };

  initial begin
    hash_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].has_ref) begin
        // typed-in check of the leading digest word on top of the predictor
        send_item(dir_rows[r].data, dir_rows[r].has_byte, dir_rows[r].eom);
        if (digest_q[digest_q.size() - 8].word !== dir_rows[r].ref_w0) begin
          $error("digest_word expected %h actual %h", dir_rows[r].ref_w0,
                 digest_q[digest_q.size() - 8].word);
          fail_cnt++;
        end
      end else begin
        send_item(dir_rows[r].data, dir_rows[r].has_byte, dir_rows[r].eom);
      end
    end

    // padding boundaries: one or two final blocks, and a full block before end
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(64, 1'b1);

    // sender holds off until every digest word is out
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);

    // random messages, mostly short, with stray idle items mixed in
    while (items_sent < 220) begin
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(12);
      if ($urandom_range(3) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_message(len, 1'($urandom_range(1)));
    end

    // no idling at all on the last stretch
    quiet_mode = 1'b1;
    for (int i = 0; i < 4; i++) send_message($urandom_range(20, 10), 1'($urandom_range(1)));
    in_valid <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("sent %0d items, %0d digests checked, incl. empty, padding-boundary and idle cases",
             items_sent, digests_seen);
    if (fail_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/sha256_pkg.sv
src/sha256_datapath.sv
src/sha256_ctrl.sv
src/sha256_lenload.sv
src/sha256_hasher.sv
sim/tb_top.sv
